[sv/vnds_pkg.sv]
// Shared types, constants and helper functions for the voxel neighbourhood density score block.
// Used by vnds_ctrl, vnds_dp and the top level; depends on nothing else.
package vnds_pkg;

	localparam int GRID_X_DEF     = 80;
	localparam int GRID_Y_DEF     = 69;
	localparam int GRID_Z_DEF     = 57;
	localparam int COUNT_BITS_DEF = 16;

	localparam int COORD_W = 12;
	localparam int VOXEL_W = 8;
	localparam int OFFS_W  = 8;
	localparam int RAD_W   = 2;
	localparam int POS_W   = 10;
	localparam int SCORE_W = 31;
	localparam int CELLS_W = 7;
	localparam int DEN_W   = 8;
	localparam int SCALE_W = 13;

	localparam logic [SCALE_W-1:0] SCORE_SCALE = 13'd6400;
	localparam logic [SCORE_W-1:0] SCORE_MAX   = 31'h7FFF_FFFF;

	localparam logic [OFFS_W-1:0] OFFSET_X_RST = 8'd40;
	localparam logic [OFFS_W-1:0] OFFSET_Y_RST = 8'd34;
	localparam logic [OFFS_W-1:0] OFFSET_Z_RST = 8'd28;
	localparam logic [RAD_W-1:0]  RADIUS_RST   = 2'd3;

	localparam logic [1:0] REG_OFFSET_X = 2'd0;
	localparam logic [1:0] REG_OFFSET_Y = 2'd1;
	localparam logic [1:0] REG_OFFSET_Z = 2'd2;
	localparam logic [1:0] REG_RADIUS   = 2'd3;

	localparam logic REQ_ADD   = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	typedef struct packed {
		logic clear;
		logic load;
		logic inject;
		logic walk_init;
		logic walk_run;
		logic div_start;
		logic div_run;
		logic out_load;
	} vnds_cmd_t;

	typedef struct packed {
		logic clear_done;
		logic walk_last;
		logic pipe_empty;
		logic div_done;
	} vnds_sts_t;

	function automatic logic signed [POS_W-1:0] round_coord(input logic signed [COORD_W-1:0] c);
		logic signed [COORD_W:0] t;
		logic signed [POS_W-1:0] q;
		begin
			t = (COORD_W+1)'(c) + 13'sd8;
			q = POS_W'(t >>> 4);
			if (t[COORD_W] && (t[3:0] != 4'd0)) begin
				q = q + 10'sd1;
			end
			return q;
		end
	endfunction

	function automatic logic signed [3:0] abs3(input logic signed [2:0] a);
		begin
			return a[2] ? -4'(a) : 4'(a);
		end
	endfunction

	function automatic logic signed [3:0] span_lim(input logic [RAD_W-1:0] d,
		input logic signed [2:0] a, input logic signed [2:0] b);
		logic signed [3:0] r;
		logic signed [3:0] ds;
		begin
			ds = $signed({2'b00, d});
			r = 4'sd3 - abs3(a) - abs3(b);
			return (r < ds) ? r : ds;
		end
	endfunction

endpackage

[sv/vnds_ctrl.sv]
// Controller state machine for the voxel neighbourhood density score block.
// Depends on vnds_pkg; drives the datapath vnds_dp through command and status structs.
module vnds_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                req_type,
	output logic                out_valid,
	input  logic                out_stall,
	input  vnds_pkg::vnds_sts_t sts,
	output vnds_pkg::vnds_cmd_t cmd
);

	typedef enum logic [9:0] {
		ST_CLEAR     = 10'b00_0000_0001,
		ST_IDLE      = 10'b00_0000_0010,
		ST_ADD       = 10'b00_0000_0100,
		ST_ADD_WAIT  = 10'b00_0000_1000,
		ST_WALK_INIT = 10'b00_0001_0000,
		ST_WALK      = 10'b00_0010_0000,
		ST_DRAIN     = 10'b00_0100_0000,
		ST_DIV_START = 10'b00_1000_0000,
		ST_DIV       = 10'b01_0000_0000,
		ST_FINISH    = 10'b10_0000_0000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_full_q;
	logic   accept;
	logic   out_free;

	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_full_q;
	assign out_free  = !out_full_q || !out_stall;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (sts.clear_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					cmd.load = 1'b1;
					state_d  = (req_type == vnds_pkg::REQ_QUERY) ? ST_WALK_INIT : ST_ADD;
				end
			end
			ST_ADD: begin
				cmd.inject = 1'b1;
				state_d    = ST_ADD_WAIT;
			end
			ST_ADD_WAIT: begin
				if (sts.pipe_empty) begin
					state_d = ST_IDLE;
				end
			end
			ST_WALK_INIT: begin
				cmd.walk_init = 1'b1;
				state_d       = ST_WALK;
			end
			ST_WALK: begin
				cmd.walk_run = 1'b1;
				if (sts.walk_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (sts.pipe_empty) begin
					state_d = ST_DIV_START;
				end
			end
			ST_DIV_START: begin
				cmd.div_start = 1'b1;
				state_d       = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_run = 1'b1;
				if (sts.div_done) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			out_full_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_full_q <= 1'b1;
			end else if (out_full_q && !out_stall) begin
				out_full_q <= 1'b0;
			end
		end
	end

endmodule

[sv/vnds_dp.sv]
// Datapath of the voxel neighbourhood density score block: count memory, cell walk,
// address pipeline, accumulator and bit-serial divider. Depends on vnds_pkg.
module vnds_dp #(
	parameter int GRID_X     = vnds_pkg::GRID_X_DEF,
	parameter int GRID_Y     = vnds_pkg::GRID_Y_DEF,
	parameter int GRID_Z     = vnds_pkg::GRID_Z_DEF,
	parameter int COUNT_BITS = vnds_pkg::COUNT_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [1:0]                           cfg_index,
	input  logic [vnds_pkg::OFFS_W-1:0]          cfg_data,
	input  logic                                 req_type,
	input  logic signed [vnds_pkg::COORD_W-1:0]  coord_x,
	input  logic signed [vnds_pkg::COORD_W-1:0]  coord_y,
	input  logic signed [vnds_pkg::COORD_W-1:0]  coord_z,
	input  logic [vnds_pkg::VOXEL_W-1:0]         voxel_x,
	input  logic [vnds_pkg::VOXEL_W-1:0]         voxel_y,
	input  logic [vnds_pkg::VOXEL_W-1:0]         voxel_z,
	input  vnds_pkg::vnds_cmd_t                  cmd,
	output vnds_pkg::vnds_sts_t                  sts,
	output logic [vnds_pkg::SCORE_W-1:0]         density_score,
	output logic                                 empty_region
);

	localparam int TOTAL  = GRID_X * GRID_Y * GRID_Z;
	localparam int ADDR_W = $clog2(TOTAL);
	localparam int TERM_W = COUNT_BITS + 4;
	localparam int SUM_W  = COUNT_BITS + 10;
	localparam int NUM_W  = SUM_W + vnds_pkg::SCALE_W;
	localparam int CNT_W  = $clog2(NUM_W);
	localparam int POS_W  = vnds_pkg::POS_W;

	localparam logic [COUNT_BITS-1:0]  LIMIT     = '1;
	localparam logic [ADDR_W-1:0]      LAST_ADDR = ADDR_W'(TOTAL - 1);
	localparam logic [CNT_W-1:0]       LAST_STEP = CNT_W'(NUM_W - 1);
	localparam logic signed [POS_W-1:0] LIM_X    = POS_W'(GRID_X);
	localparam logic signed [POS_W-1:0] LIM_Y    = POS_W'(GRID_Y);
	localparam logic signed [POS_W-1:0] LIM_Z    = POS_W'(GRID_Z);

	logic [vnds_pkg::OFFS_W-1:0] off_x_q, off_y_q, off_z_q;
	logic [vnds_pkg::RAD_W-1:0]  radius_q;

	logic                                query_q;
	logic signed [vnds_pkg::COORD_W-1:0] cx_q, cy_q, cz_q;
	logic [vnds_pkg::VOXEL_W-1:0]        vx_q, vy_q, vz_q;

	logic signed [2:0] dx_q, dy_q, dz_q;
	logic signed [2:0] rad_s;
	logic signed [3:0] lim_cur, lim_ny, lim_nx;
	logic              emit;

	logic                    src_valid;
	logic signed [POS_W-1:0] src_x, src_y, src_z;
	logic [1:0]              src_dist;

	logic                    v_s1, v_s2, v_s3, v_s4;
	logic                    ok_s1, ok_s2, ok_s3, ok_s4;
	logic signed [POS_W-1:0] x_s1, y_s1, z_s1;
	logic [1:0]              dist_s1, dist_s2, dist_s3, dist_s4;
	logic [ADDR_W-1:0]       p1_s2, addr_s3, addr_s4;
	logic [7:0]              z_s2;
	logic [COUNT_BITS-1:0]   rdata_s4;

	logic [COUNT_BITS-1:0] mem [TOTAL];
	logic                  mem_we;
	logic [ADDR_W-1:0]     mem_waddr;
	logic [COUNT_BITS-1:0] mem_wdata;
	logic [ADDR_W-1:0]     clr_addr_q;

	logic [SUM_W-1:0]           sum_q;
	logic [vnds_pkg::CELLS_W-1:0] cells_q;
	logic                       nz_q;
	logic [TERM_W-1:0]          term;

	logic [NUM_W-1:0]             num_q;
	logic [vnds_pkg::DEN_W-1:0]   den_q;
	logic [vnds_pkg::DEN_W-1:0]   rem_q;
	logic [vnds_pkg::DEN_W:0]     rem_n;
	logic                         qbit;
	logic [CNT_W-1:0]             cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_x_q  <= vnds_pkg::OFFSET_X_RST;
			off_y_q  <= vnds_pkg::OFFSET_Y_RST;
			off_z_q  <= vnds_pkg::OFFSET_Z_RST;
			radius_q <= vnds_pkg::RADIUS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				vnds_pkg::REG_OFFSET_X: off_x_q  <= cfg_data;
				vnds_pkg::REG_OFFSET_Y: off_y_q  <= cfg_data;
				vnds_pkg::REG_OFFSET_Z: off_z_q  <= cfg_data;
				vnds_pkg::REG_RADIUS:   radius_q <= cfg_data[vnds_pkg::RAD_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			query_q <= req_type;
			cx_q    <= coord_x;
			cy_q    <= coord_y;
			cz_q    <= coord_z;
			vx_q    <= voxel_x;
			vy_q    <= voxel_y;
			vz_q    <= voxel_z;
		end
	end

	assign rad_s   = $signed({1'b0, radius_q});
	assign lim_cur = vnds_pkg::span_lim(radius_q, dx_q, dy_q);
	assign lim_ny  = vnds_pkg::span_lim(radius_q, dx_q, dy_q + 3'sd1);
	assign lim_nx  = vnds_pkg::span_lim(radius_q, dx_q + 3'sd1, -rad_s);
	assign emit    = (4'(dz_q) <= lim_cur);

	assign sts.walk_last = (4'(dz_q) >= lim_cur) && (dy_q == rad_s) && (dx_q == rad_s);

	always_ff @(posedge clk) begin
		if (cmd.walk_init) begin
			dx_q <= -rad_s;
			dy_q <= -rad_s;
			dz_q <= -3'(vnds_pkg::span_lim(radius_q, -rad_s, -rad_s));
		end else if (cmd.walk_run) begin
			if (4'(dz_q) < lim_cur) begin
				dz_q <= dz_q + 3'sd1;
			end else if (dy_q != rad_s) begin
				dy_q <= dy_q + 3'sd1;
				dz_q <= -3'(lim_ny);
			end else if (dx_q != rad_s) begin
				dx_q <= dx_q + 3'sd1;
				dy_q <= -rad_s;
				dz_q <= -3'(lim_nx);
			end
		end
	end

	always_comb begin
		src_valid = cmd.inject || (cmd.walk_run && emit);
		src_dist  = 2'(vnds_pkg::abs3(dx_q) + vnds_pkg::abs3(dy_q) + vnds_pkg::abs3(dz_q));
		if (query_q == vnds_pkg::REQ_QUERY) begin
			src_x = $signed({2'b00, vx_q}) + POS_W'(dx_q);
			src_y = $signed({2'b00, vy_q}) + POS_W'(dy_q);
			src_z = $signed({2'b00, vz_q}) + POS_W'(dz_q);
		end else begin
			src_x = $signed({2'b00, off_x_q}) - vnds_pkg::round_coord(cx_q);
			src_y = $signed({2'b00, off_y_q}) - vnds_pkg::round_coord(cy_q);
			src_z = $signed({2'b00, off_z_q}) - vnds_pkg::round_coord(cz_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= src_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	assign sts.pipe_empty = !(v_s1 || v_s2 || v_s3 || v_s4);

	always_ff @(posedge clk) begin
		x_s1    <= src_x;
		y_s1    <= src_y;
		z_s1    <= src_z;
		dist_s1 <= src_dist;
		ok_s1   <= (src_x >= 0) && (src_x < LIM_X) && (src_y >= 0) && (src_y < LIM_Y)
			&& (src_z >= 0) && (src_z < LIM_Z);
		p1_s2   <= ADDR_W'(x_s1[7:0]) * ADDR_W'(GRID_Y) + ADDR_W'(y_s1[7:0]);
		z_s2    <= z_s1[7:0];
		ok_s2   <= ok_s1;
		dist_s2 <= dist_s1;
		addr_s3 <= p1_s2 * ADDR_W'(GRID_Z) + ADDR_W'(z_s2);
		ok_s3   <= ok_s2;
		dist_s3 <= dist_s2;
		addr_s4 <= addr_s3;
		ok_s4   <= ok_s3;
		dist_s4 <= dist_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (cmd.clear) begin
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	assign sts.clear_done = (clr_addr_q == LAST_ADDR);

	always_comb begin
		if (cmd.clear) begin
			mem_we    = 1'b1;
			mem_waddr = clr_addr_q;
			mem_wdata = '0;
		end else begin
			mem_we    = v_s4 && ok_s4 && (query_q == vnds_pkg::REQ_ADD) && (rdata_s4 != LIMIT);
			mem_waddr = addr_s4;
			mem_wdata = rdata_s4 + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rdata_s4 <= mem[addr_s3];
	end

	always_comb begin
		case (dist_s4)
			2'd0:    term = TERM_W'(rdata_s4) * TERM_W'(12);
			2'd1:    term = TERM_W'(rdata_s4) * TERM_W'(6);
			2'd2:    term = TERM_W'(rdata_s4) * TERM_W'(4);
			default: term = TERM_W'(rdata_s4) * TERM_W'(3);
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.walk_init) begin
			sum_q   <= '0;
			cells_q <= '0;
			nz_q    <= 1'b0;
		end else if (v_s4 && ok_s4 && (query_q == vnds_pkg::REQ_QUERY)) begin
			sum_q   <= sum_q + SUM_W'(term);
			cells_q <= cells_q + 1'b1;
			nz_q    <= nz_q || (rdata_s4 != '0);
		end
	end

	assign rem_n = {rem_q, num_q[NUM_W-1]};
	assign qbit  = (rem_n >= {1'b0, den_q});

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			num_q <= NUM_W'(sum_q) * NUM_W'(vnds_pkg::SCORE_SCALE);
			den_q <= vnds_pkg::DEN_W'(cells_q) * vnds_pkg::DEN_W'(3);
			rem_q <= '0;
			cnt_q <= '0;
		end else if (cmd.div_run) begin
			rem_q <= qbit ? vnds_pkg::DEN_W'(rem_n - {1'b0, den_q}) : vnds_pkg::DEN_W'(rem_n);
			num_q <= {num_q[NUM_W-2:0], qbit};
			cnt_q <= cnt_q + 1'b1;
		end
	end

	assign sts.div_done = (cnt_q == LAST_STEP);

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			if (cells_q == '0) begin
				density_score <= '0;
			end else if (num_q > NUM_W'(vnds_pkg::SCORE_MAX)) begin
				density_score <= vnds_pkg::SCORE_MAX;
			end else begin
				density_score <= vnds_pkg::SCORE_W'(num_q);
			end
			empty_region <= (cells_q > vnds_pkg::CELLS_W'(1)) && !nz_q;
		end
	end

endmodule

[sv/voxel_neighborhood_density_score_top.sv]
// Top level of the voxel neighbourhood density score block; depends on vnds_pkg,
// vnds_ctrl and vnds_dp.
// After an add request is accepted, the next request is taken only once its update has left the address pipeline.
// A query's result is offered after the cell walk, the pipeline drain and the division, where the
// walk steps one position a cycle through the count memory port and the divider takes one
// bit a step; the next request can be taken in the cycle the result is offered, and
// a result still held at the output delays the one behind it.
// After reset the count memory is cleared one entry a cycle, during which no request is taken;
// configuration writes are taken at any time.
module voxel_neighborhood_density_score_top #(
	parameter int GRID_X     = vnds_pkg::GRID_X_DEF,
	parameter int GRID_Y     = vnds_pkg::GRID_Y_DEF,
	parameter int GRID_Z     = vnds_pkg::GRID_Z_DEF,
	parameter int COUNT_BITS = vnds_pkg::COUNT_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [1:0]                          cfg_index,
	input  logic [vnds_pkg::OFFS_W-1:0]         cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                req_type,
	input  logic signed [vnds_pkg::COORD_W-1:0] coord_x,
	input  logic signed [vnds_pkg::COORD_W-1:0] coord_y,
	input  logic signed [vnds_pkg::COORD_W-1:0] coord_z,
	input  logic [vnds_pkg::VOXEL_W-1:0]        voxel_x,
	input  logic [vnds_pkg::VOXEL_W-1:0]        voxel_y,
	input  logic [vnds_pkg::VOXEL_W-1:0]        voxel_z,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [vnds_pkg::SCORE_W-1:0]        density_score,
	output logic                                empty_region
);

	vnds_pkg::vnds_cmd_t cmd;
	vnds_pkg::vnds_sts_t sts;

	vnds_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.req_type  (req_type),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	vnds_dp #(
		.GRID_X     (GRID_X),
		.GRID_Y     (GRID_Y),
		.GRID_Z     (GRID_Z),
		.COUNT_BITS (COUNT_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.req_type      (req_type),
		.coord_x       (coord_x),
		.coord_y       (coord_y),
		.coord_z       (coord_z),
		.voxel_x       (voxel_x),
		.voxel_y       (voxel_y),
		.voxel_z       (voxel_z),
		.cmd           (cmd),
		.sts           (sts),
		.density_score (density_score),
		.empty_region  (empty_region)
	);

	a_empty_means_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && empty_region) |-> (density_score == '0))
		else $error("empty region reported with a nonzero score");

	a_busy_after_request: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("request taken while the previous one is still in work");

	a_single_command: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.clear, cmd.load, cmd.inject, cmd.walk_init, cmd.walk_run,
			cmd.div_start, cmd.div_run, cmd.out_load}))
		else $error("controller issued more than one command at once");

endmodule
